FILE: hdl/pcd_pkg.sv
// ----------------------------------------------------------------------------
// pcd_pkg
// Shared types and constants of the correlation dissimilarity unit: beat
// structs, accumulator widths, job record and fixed-point constants.
// ----------------------------------------------------------------------------
package pcd_pkg;

  // Longest vector that is accumulated; further present pairs are dropped
  localparam int unsigned MAX_LEN = 4096;

  // Accumulator widths follow from the vector length and Q8.8 samples
  localparam int unsigned CNT_W   = $clog2(MAX_LEN + 1);
  localparam int unsigned SX_W    = 16 + CNT_W;
  localparam int unsigned SXX_W   = 30 + CNT_W;
  localparam int unsigned SXY_W   = 31 + CNT_W;

  // Finishing arithmetic widths
  localparam int unsigned TW      = CNT_W + SXY_W;       // |num|, vx, vy
  localparam int unsigned NW      = TW + 1;              // signed num
  localparam int unsigned PW      = 2 * TW;              // vx * vy
  localparam int unsigned FRAC_W  = 14;                  // Q1.14 result
  localparam int unsigned TGT_SH  = 2 * FRAC_W + 2;      // 4 * 2^28
  localparam int unsigned CW      = PW + TGT_SH + 1;     // compare width
  localparam int unsigned K_W     = FRAC_W + 1;          // 0 .. ONE_Q
  localparam int unsigned TSQ_W   = 2 * K_W;
  localparam int unsigned ONE_Q   = 1 << FRAC_W;

  // Shared multiplier operand widths
  localparam int unsigned MUL_AW  = PW;
  localparam int unsigned MUL_BW  = TW;

  // Job queue depth between front and back
  localparam int unsigned JOBQ_DEPTH = 2;

  // Result field widths
  localparam int unsigned DIS_W   = 16;
  localparam int unsigned PAIRS_W = 13;

  // Register map
  localparam int unsigned REG_METRIC_MODE = 0;

  typedef struct packed {
    logic signed [15:0] x_value;
    logic signed [15:0] y_value;
    logic               x_missing;
    logic               y_missing;
    logic               last_pair;
  } in_item_t;

  typedef struct packed {
    logic [DIS_W-1:0]   dissimilarity;
    logic               bad_result;
    logic [PAIRS_W-1:0] pairs_used;
  } out_item_t;

  // Snapshot of the sums of one finished vector
  typedef struct packed {
    logic [CNT_W-1:0]        n;
    logic signed [SX_W-1:0]  sx;
    logic signed [SX_W-1:0]  sy;
    logic [SXX_W-1:0]        sxx;
    logic [SXX_W-1:0]        syy;
    logic signed [SXY_W-1:0] sxy;
  } job_t;

endpackage

FILE: hdl/pairwise_correlation_dissimilarity_unit.sv
// ----------------------------------------------------------------------------
// pairwise_correlation_dissimilarity_unit
// Streaming Pearson / cosine dissimilarity with exact integer sums.
// ----------------------------------------------------------------------------
// Throughput: one element pair per cycle; ready drops only while two
//   finished vectors wait in the job queue for the finishing sequencer.
// Finishing: the shared multiplier, built on 32x32 partial products, serves
//   six sum products (correlation only), the norm product, the squared
//   numerator and up to 15 search probes; a zero norm product ends the job
//   before the squared numerator.
// Reset: asynchronous, clears sums, queue, sequencer and metric_mode.
module pairwise_correlation_dissimilarity_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pcd_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pcd_pkg::out_item_t out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import pcd_pkg::*;

  logic [1:0] mode_q;
  logic       q_full, push, pop, job_valid;
  job_t       push_job, head_job;

  // configuration register: single register; writes to any address reach it, reads return it only at address 0
  assign pready = 1'b1;
  assign prdata = (paddr[1:0] == 2'(REG_METRIC_MODE * 4)) ? {30'd0, mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 2'd0;
    end else if (psel && penable && pwrite && pready) begin
      mode_q <= pwdata[1:0];
    end
  end

  pcd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i (in_data_i),
    .q_full_i  (q_full),
    .push_o    (push),
    .job_o     (push_job)
  );

  pcd_jobq #(
    .DEPTH(JOBQ_DEPTH)
  ) u_jobq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .full_o (q_full),
    .pop_i  (pop),
    .valid_o(job_valid),
    .job_o  (head_job)
  );

  pcd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(job_valid),
    .job_i      (head_job),
    .job_pop_o  (pop),
    .mode_i     (mode_q),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o)
  );

endmodule

FILE: hdl/pcd_front.sv
// ----------------------------------------------------------------------------
// pcd_front
// Takes one element pair per beat, skips pairs with a missing element and
// accumulates the exact sums. The last pair pushes the sums as a job.
// ----------------------------------------------------------------------------
module pcd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  pcd_pkg::in_item_t in_data_i,
  input  logic             q_full_i,
  output logic             push_o,
  output pcd_pkg::job_t    job_o
);
  import pcd_pkg::*;

  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic signed [SX_W-1:0]  sx_q, sx_d, sy_q, sy_d;
  logic [SXX_W-1:0]        sxx_q, sxx_d, syy_q, syy_d;
  logic signed [SXY_W-1:0] sxy_q, sxy_d;
  logic signed [31:0]      pxx, pyy, pxy;
  logic                    take, accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign take       = !in_data_i.x_missing && !in_data_i.y_missing &&
                      (cnt_q < CNT_W'(MAX_LEN));

  // products of the current pair
  assign pxx = in_data_i.x_value * in_data_i.x_value;
  assign pyy = in_data_i.y_value * in_data_i.y_value;
  assign pxy = in_data_i.x_value * in_data_i.y_value;

  // sums including the current pair
  always_comb begin
    cnt_d = cnt_q;
    sx_d  = sx_q;
    sy_d  = sy_q;
    sxx_d = sxx_q;
    syy_d = syy_q;
    sxy_d = sxy_q;
    if (take) begin
      cnt_d = cnt_q + 1'b1;
      sx_d  = sx_q + {{(SX_W-16){in_data_i.x_value[15]}}, in_data_i.x_value};
      sy_d  = sy_q + {{(SX_W-16){in_data_i.y_value[15]}}, in_data_i.y_value};
      sxx_d = sxx_q + {{(SXX_W-32){1'b0}}, pxx};
      syy_d = syy_q + {{(SXX_W-32){1'b0}}, pyy};
      sxy_d = sxy_q + {{(SXY_W-32){pxy[31]}}, pxy};
    end
  end

  assign push_o    = accept && in_data_i.last_pair;
  assign job_o.n   = cnt_d;
  assign job_o.sx  = sx_d;
  assign job_o.sy  = sy_d;
  assign job_o.sxx = sxx_d;
  assign job_o.syy = syy_d;
  assign job_o.sxy = sxy_d;

  // accumulators, cleared after each last pair
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sx_q  <= '0;
      sy_q  <= '0;
      sxx_q <= '0;
      syy_q <= '0;
      sxy_q <= '0;
    end else if (accept) begin
      if (in_data_i.last_pair) begin
        cnt_q <= '0;
        sx_q  <= '0;
        sy_q  <= '0;
        sxx_q <= '0;
        syy_q <= '0;
        sxy_q <= '0;
      end else begin
        cnt_q <= cnt_d;
        sx_q  <= sx_d;
        sy_q  <= sy_d;
        sxx_q <= sxx_d;
        syy_q <= syy_d;
        sxy_q <= sxy_d;
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_LEN))
    else $error("pair count above limit");
`endif

endmodule

FILE: hdl/pcd_jobq.sv
// ----------------------------------------------------------------------------
// pcd_jobq
// Short queue of finished-vector jobs between the accumulating front and
// the finishing back.
// ----------------------------------------------------------------------------
module pcd_jobq #(
  parameter int unsigned DEPTH = pcd_pkg::JOBQ_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pcd_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output pcd_pkg::job_t job_o
);
  import pcd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_QW = $clog2(DEPTH + 1);

  job_t              mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [CNT_QW-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_QW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/pcd_mul.sv
// ----------------------------------------------------------------------------
// pcd_mul
// Multi-cycle unsigned multiplier: one 32x32 partial product per cycle,
// registered, then shifted into a wide accumulator.
// ----------------------------------------------------------------------------
module pcd_mul #(
  parameter int unsigned AW = pcd_pkg::MUL_AW,
  parameter int unsigned BW = pcd_pkg::MUL_BW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic             done_o,
  output logic [AW+BW-1:0] p_o
);
  // limb counts are at least two for every operand width in use
  localparam int unsigned LA    = (AW + 31) / 32;
  localparam int unsigned LB    = (BW + 31) / 32;
  localparam int unsigned IA_W  = $clog2(LA);
  localparam int unsigned JB_W  = $clog2(LB);
  localparam int unsigned SH_W  = $clog2(LA + LB - 1);
  localparam int unsigned ACC_W = (LA + LB) * 32;

  logic [LA*32-1:0] a_pad;
  logic [LB*32-1:0] b_pad;
  logic [IA_W-1:0]  ia_q;
  logic [JB_W-1:0]  jb_q;
  logic             run_q, pp_vld_q, pp_last_q, done_q;
  logic [63:0]      pp_q;
  logic [SH_W-1:0]  sh_q;
  logic [ACC_W-1:0] acc_q;
  logic             last_issue;

  assign a_pad      = {{(LA*32-AW){1'b0}}, a_i};
  assign b_pad      = {{(LB*32-BW){1'b0}}, b_i};
  assign last_issue = (ia_q == IA_W'(LA - 1)) && (jb_q == JB_W'(LB - 1));

  // partial product issue
  always_ff @(posedge clk_i) begin
    pp_q <= a_pad[{ia_q, 5'd0} +: 32] * b_pad[{jb_q, 5'd0} +: 32];
    sh_q <= SH_W'(ia_q) + SH_W'(jb_q);
  end

  // control: limb counters and pipeline flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q     <= 1'b0;
      ia_q      <= '0;
      jb_q      <= '0;
      pp_vld_q  <= 1'b0;
      pp_last_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      pp_vld_q  <= run_q;
      pp_last_q <= run_q && last_issue;
      done_q    <= pp_vld_q && pp_last_q;
      if (start_i) begin
        run_q <= 1'b1;
        ia_q  <= '0;
        jb_q  <= '0;
      end else if (run_q) begin
        if (jb_q == JB_W'(LB - 1)) begin
          jb_q <= '0;
          ia_q <= ia_q + 1'b1;
        end else begin
          jb_q <= jb_q + 1'b1;
        end
        if (last_issue) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  // accumulate shifted partial products
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
    end else if (pp_vld_q) begin
      acc_q <= acc_q + ({{(ACC_W-64){1'b0}}, pp_q} << {sh_q, 5'd0});
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q[AW+BW-1:0];

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("multiplier done held for two cycles");
`endif

endmodule

FILE: hdl/pcd_back.sv
// ----------------------------------------------------------------------------
// pcd_back
// Finishes one job at a time: forms numerator and variances on the shared
// multiplier (correlation mode), then binary-searches the rounded Q1.14 |c|.
// ----------------------------------------------------------------------------
module pcd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  input  pcd_pkg::job_t      job_i,
  output logic               job_pop_o,
  input  logic [1:0]         mode_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output pcd_pkg::out_item_t out_data_o
);
  import pcd_pkg::*;

  localparam int unsigned ST_W   = 3;
  localparam logic [ST_W-1:0] ST_IDLE  = 3'd0;
  localparam logic [ST_W-1:0] ST_ISSUE = 3'd1;
  localparam logic [ST_W-1:0] ST_MUL   = 3'd2;
  localparam logic [ST_W-1:0] ST_TSQ   = 3'd3;
  localparam logic [ST_W-1:0] ST_WAIT  = 3'd4;

  localparam int unsigned OP_W   = 4;
  localparam logic [OP_W-1:0] OP_NSXY = 4'd0;
  localparam logic [OP_W-1:0] OP_SXSY = 4'd1;
  localparam logic [OP_W-1:0] OP_NSXX = 4'd2;
  localparam logic [OP_W-1:0] OP_SXSX = 4'd3;
  localparam logic [OP_W-1:0] OP_NSYY = 4'd4;
  localparam logic [OP_W-1:0] OP_SYSY = 4'd5;
  localparam logic [OP_W-1:0] OP_VXVY = 4'd6;
  localparam logic [OP_W-1:0] OP_MAG  = 4'd7;
  localparam logic [OP_W-1:0] OP_LHS  = 4'd8;

  logic [ST_W-1:0]      st_q;
  logic [OP_W-1:0]      op_q;
  job_t                 job_q;
  logic                 abs_q;
  logic signed [NW-1:0] num_q, vx_q, vy_q;
  logic [PW-1:0]        prod_q;
  logic [CW-1:0]        tgt_q;
  logic [K_W-1:0]       lo_q, hi_q, mid_q;
  logic [TSQ_W-1:0]     tsq_q;
  out_item_t            res_q, out_q;
  logic                 out_valid_q;

  logic [MUL_AW-1:0]        mul_a;
  logic [MUL_BW-1:0]        mul_b;
  logic                     mul_start, mul_done, op_neg;
  logic [MUL_AW+MUL_BW-1:0] mul_p;

  logic [SX_W-1:0]      sx_mag, sy_mag;
  logic [SXY_W-1:0]     sxy_mag;
  logic [NW-1:0]        num_abs;
  logic signed [NW-1:0] pos_v, sval;
  logic [K_W:0]         msum, tval;
  logic [K_W-1:0]       mid_c, lo_n, hi_n;
  logic                 le, slot_free;
  logic [DIS_W-1:0]     dis_c;

  // operand magnitudes
  assign sx_mag  = job_q.sx[SX_W-1]   ? (~job_q.sx + 1'b1)  : job_q.sx;
  assign sy_mag  = job_q.sy[SX_W-1]   ? (~job_q.sy + 1'b1)  : job_q.sy;
  assign sxy_mag = job_q.sxy[SXY_W-1] ? (~job_q.sxy + 1'b1) : job_q.sxy;
  assign num_abs = num_q[NW-1] ? (~num_q + 1'b1) : num_q;

  // operand select per step
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    op_neg = 1'b0;
    case (op_q)
      OP_NSXY: begin
        mul_a  = MUL_AW'(job_q.n);
        mul_b  = MUL_BW'(sxy_mag);
        op_neg = job_q.sxy[SXY_W-1];
      end
      OP_SXSY: begin
        mul_a  = MUL_AW'(sx_mag);
        mul_b  = MUL_BW'(sy_mag);
        op_neg = job_q.sx[SX_W-1] ^ job_q.sy[SX_W-1];
      end
      OP_NSXX: begin
        mul_a = MUL_AW'(job_q.n);
        mul_b = MUL_BW'(job_q.sxx);
      end
      OP_SXSX: begin
        mul_a = MUL_AW'(sx_mag);
        mul_b = MUL_BW'(sx_mag);
      end
      OP_NSYY: begin
        mul_a = MUL_AW'(job_q.n);
        mul_b = MUL_BW'(job_q.syy);
      end
      OP_SYSY: begin
        mul_a = MUL_AW'(sy_mag);
        mul_b = MUL_BW'(sy_mag);
      end
      OP_VXVY: begin
        mul_a = MUL_AW'(vx_q[TW-1:0]);
        mul_b = MUL_BW'(vy_q[TW-1:0]);
      end
      OP_MAG: begin
        mul_a = MUL_AW'(num_abs[TW-1:0]);
        mul_b = MUL_BW'(num_abs[TW-1:0]);
      end
      OP_LHS: begin
        mul_a = prod_q;
        mul_b = MUL_BW'(tsq_q);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign mul_start = (st_q == ST_ISSUE);

  pcd_mul #(
    .AW(MUL_AW),
    .BW(MUL_BW)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .p_o    (mul_p)
  );

  // signed term from the product
  assign pos_v = {1'b0, mul_p[TW-1:0]};
  assign sval  = op_neg ? -pos_v : pos_v;

  // search step: next probe and its update
  assign msum  = {1'b0, lo_q} + {1'b0, hi_q} + 1'b1;
  assign mid_c = msum[K_W:1];
  assign tval  = {mid_c, 1'b0} - 1'b1;
  assign le    = (mul_p[CW-1:0] <= tgt_q);
  assign lo_n  = le ? mid_q : lo_q;
  assign hi_n  = le ? hi_q : (mid_q - 1'b1);
  assign dis_c = (num_q[NW-1] && !abs_q) ? (DIS_W'(ONE_Q) + DIS_W'(lo_n))
                                         : (DIS_W'(ONE_Q) - DIS_W'(lo_n));

  assign job_pop_o = (st_q == ST_IDLE) && job_valid_i;
  assign slot_free = !out_valid_q || out_ready_i;

  // sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      op_q <= OP_NSXY;
    end else begin
      case (st_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            op_q <= mode_i[1] ? OP_VXVY : OP_NSXY;
            st_q <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          st_q <= ST_MUL;
        end
        ST_MUL: begin
          if (mul_done) begin
            case (op_q)
              OP_VXVY: begin
                if (mul_p[PW-1:0] == '0) begin
                  st_q <= ST_WAIT;
                end else begin
                  op_q <= OP_MAG;
                  st_q <= ST_ISSUE;
                end
              end
              OP_MAG: begin
                st_q <= ST_TSQ;
              end
              OP_LHS: begin
                st_q <= (lo_n < hi_n) ? ST_TSQ : ST_WAIT;
              end
              default: begin
                op_q <= op_q + 1'b1;
                st_q <= ST_ISSUE;
              end
            endcase
          end
        end
        ST_TSQ: begin
          op_q <= OP_LHS;
          st_q <= ST_ISSUE;
        end
        ST_WAIT: begin
          if (slot_free) begin
            st_q <= ST_IDLE;
          end
        end
        default: begin
          st_q <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          job_q <= job_i;
          abs_q <= mode_i[0];
          num_q <= {{(NW-SXY_W){job_i.sxy[SXY_W-1]}}, job_i.sxy};
          vx_q  <= {{(NW-SXX_W){1'b0}}, job_i.sxx};
          vy_q  <= {{(NW-SXX_W){1'b0}}, job_i.syy};
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          case (op_q)
            OP_NSXY: num_q <= sval;
            OP_SXSY: num_q <= num_q - sval;
            OP_NSXX: vx_q  <= sval;
            OP_SXSX: vx_q  <= vx_q - sval;
            OP_NSYY: vy_q  <= sval;
            OP_SYSY: vy_q  <= vy_q - sval;
            OP_VXVY: begin
              prod_q <= mul_p[PW-1:0];
              res_q.dissimilarity <= '0;
              res_q.bad_result    <= 1'b1;
              res_q.pairs_used    <= PAIRS_W'(job_q.n);
            end
            OP_MAG: begin
              tgt_q <= {1'b0, mul_p[PW-1:0], {TGT_SH{1'b0}}};
              lo_q  <= '0;
              hi_q  <= K_W'(ONE_Q);
            end
            OP_LHS: begin
              lo_q <= lo_n;
              hi_q <= hi_n;
              res_q.dissimilarity <= dis_c;
              res_q.bad_result    <= 1'b0;
              res_q.pairs_used    <= PAIRS_W'(job_q.n);
            end
            default: begin
              prod_q <= prod_q;
            end
          endcase
        end
      end
      ST_TSQ: begin
        mid_q <= mid_c;
        tsq_q <= tval[K_W-1:0] * tval[K_W-1:0];
      end
      default: begin
        mid_q <= mid_q;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (st_q == ST_WAIT && slot_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_WAIT && slot_free) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.bad_result |-> out_q.dissimilarity == '0)
    else $error("bad result with nonzero dissimilarity");
  a_dis_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.dissimilarity <= DIS_W'(2 * ONE_Q))
    else $error("dissimilarity above two");
  a_pop_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |=> st_q == ST_ISSUE)
    else $error("job taken without starting work");
`endif

endmodule
